// ===== hw/rtl/keyed_round_robin_slot_allocator_top_defines.svh =====
// Assertion macros shared by the slot allocator's checker.
`ifndef KEYED_ROUND_ROBIN_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define KEYED_ROUND_ROBIN_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot allocator check failed");

`endif

// ===== hw/rtl/krr_pkg.sv =====
// Shared widths, codes and bus types of the keyed round-robin slot allocator.
package krr_pkg;

  localparam int IP_W        = 32;
  localparam int TAIL_W      = 24;
  localparam int OUI_W       = 24;
  localparam int SLOT_W      = 6;
  localparam int SEL_SPAN    = 64;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int MAC_W       = 48;
  localparam int POOL_SIZE_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 7'd64;

  // Request codes carried by an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_LOAD    = 2'd2
  } krr_mode_t;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_EXIST    = 3'd0,
    ST_NEW      = 3'd1,
    ST_RELEASED = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_ZERO_IP  = 3'd5,
    ST_LOADED   = 3'd6
  } krr_status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_SIZE  = 1'd0,
    CFG_OUI_PREFIX = 1'd1
  } krr_cfg_t;

  // Candidate kinds, ordered so that a larger code wins.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WRAP = 2'd1,
    KIND_FREE = 2'd2,
    KIND_HIT  = 2'd3
  } krr_kind_t;

  // Search token that walks the cell chain.
  typedef struct packed {
    logic              active;
    logic              alloc;
    logic [IP_W-1:0]   ip;
    krr_kind_t         kind;
    logic [TAIL_W-1:0] tail;
  } krr_tok_t;

  // Owner write broadcast to the cells.
  typedef struct packed {
    logic            en;
    logic            claim;
    logic [IP_W-1:0] ip;
  } krr_wr_t;

  // Tail load broadcast to the cells.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] sel;
    logic [TAIL_W-1:0] tail;
  } krr_ld_t;

endpackage

// ===== hw/rtl/krr_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface krr_in_if import krr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IP_W-1:0]   ip_address;
  logic [SLOT_W-1:0] slot_select;
  logic [TAIL_W-1:0] tail_value;

  modport source (output valid, mode, ip_address, slot_select, tail_value, input ready);
  modport sink (input valid, mode, ip_address, slot_select, tail_value, output ready);
endinterface

interface krr_out_if import krr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [MAC_W-1:0]    mac_address;

  modport source (output valid, status, slot, mac_address, input ready);
  modport sink (input valid, status, slot, mac_address, output ready);
endinterface

// ===== hw/rtl/keyed_round_robin_slot_allocator_top.sv =====
// Top level of the keyed round-robin slot allocator: cell chain and controller.
//
// Requests arrive on in_chan (valid/ready) and each one that carries a known
// mode gives one result item on out_chan; mode 3 is taken and dropped.
// Configuration (pool size, OUI prefix) is written through cfg_we, cfg_index
// and cfg_data only while the block is idle, a user rule not enforced here.
// Load requests and allocate/release requests with a zero IP finish at once:
// the result is valid the cycle after the item is taken, and such items can
// follow one per cycle while the receiver keeps up.
// Allocate and release send a search token down a row of POOL_DEPTH cells,
// one cell per cycle; the controller then latches the outcome and commits it
// together with the table write into the result register. The next item can
// be taken in the cycle in which that result is accepted.
// One item is in work at a time; in_chan.ready is high only when the
// controller is idle and the result register is empty or being drained.
// A stalled receiver holds the result register and so holds off new items.
// Synchronous reset clears every owner, every tail, the next pointer and the
// result register, and sets the pool size to 64 and the prefix to zero.
module keyed_round_robin_slot_allocator_top import krr_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  krr_in_if.sink                in_chan,
  krr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int SW = ($clog2(POOL_DEPTH + 1) > POOL_SIZE_W) ?
                      $clog2(POOL_DEPTH + 1) : POOL_SIZE_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                 state_r;
  logic [POOL_SIZE_W-1:0] pool_size_r;
  logic [OUI_W-1:0]       oui_r;
  logic [IW-1:0]          next_ptr_r;
  krr_tok_t               fin_tok_r;
  logic [IW-1:0]          fin_idx_r;
  logic                   out_valid_r;
  krr_status_t            out_status_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [MAC_W-1:0]       out_mac_r;

  logic [SW-1:0] pool_ext;
  logic [SW-1:0] size;
  logic [IW-1:0] start;
  logic [SW-1:0] nx_ext;
  logic [IW-1:0] nx_ptr;
  logic          in_ready;
  logic          acc;
  logic          search;
  logic          res_now;
  logic          commit;
  logic          fin_free;
  krr_wr_t       wr;
  krr_ld_t       ld;

  krr_tok_t      tok_w [POOL_DEPTH+1];
  logic [IW-1:0] idx_w [POOL_DEPTH+1];

  // Pool size in use and search start.
  always_comb begin
    pool_ext = SW'(pool_size_r);
    size     = (pool_ext > SW'(POOL_DEPTH)) ? SW'(POOL_DEPTH) : pool_ext;
    start    = (SW'(next_ptr_r) < size) ? next_ptr_r : '0;
    nx_ext   = SW'(fin_idx_r) + SW'(1);
    nx_ptr   = (nx_ext >= size) ? '0 : IW'(nx_ext);
  end

  // Handshake and request decode.
  always_comb begin
    in_ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
    acc      = in_chan.valid && in_ready;
    search   = ((in_chan.mode == MODE_ALLOC) || (in_chan.mode == MODE_RELEASE)) &&
               (in_chan.ip_address != '0);
    // Items that are answered in the cycle after they are taken.
    res_now  = acc && ((in_chan.mode == MODE_LOAD) ||
                       (((in_chan.mode == MODE_ALLOC) || (in_chan.mode == MODE_RELEASE)) &&
                        !search));
    tok_w[0].active = acc && search;
    tok_w[0].alloc  = in_chan.mode == MODE_ALLOC;
    tok_w[0].ip     = in_chan.ip_address;
    tok_w[0].kind   = KIND_NONE;
    tok_w[0].tail   = '0;
    idx_w[0]        = '0;
    ld.en   = acc && (in_chan.mode == MODE_LOAD);
    ld.sel  = in_chan.slot_select;
    ld.tail = in_chan.tail_value;
  end

  // Table write when a finished search is committed to the result register.
  always_comb begin
    commit   = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
    fin_free = (fin_tok_r.kind == KIND_FREE) || (fin_tok_r.kind == KIND_WRAP);
    wr.en    = commit && ((fin_tok_r.alloc && fin_free) ||
                          (!fin_tok_r.alloc && (fin_tok_r.kind == KIND_HIT)));
    wr.claim = fin_tok_r.alloc;
    wr.ip    = fin_tok_r.ip;
  end

  // Row of slot cells; the token moves one cell per cycle.
  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    krr_cell #(
      .IDX (g),
      .IW  (IW),
      .SW  (SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .size_i   (size),
      .start_i  (start),
      .wr_i     (wr),
      .wr_idx_i (fin_idx_r),
      .ld_i     (ld),
      .tok_i    (tok_w[g]),
      .idx_i    (idx_w[g]),
      .tok_o    (tok_w[g+1]),
      .idx_o    (idx_w[g+1])
    );
  end

  // Controller, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_size_r <= POOL_SIZE_RST;
      oui_r       <= '0;
      next_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_SIZE:  pool_size_r <= cfg_data[POOL_SIZE_W-1:0];
          CFG_OUI_PREFIX: oui_r       <= cfg_data[OUI_W-1:0];
          default: ;
        endcase
      end
      // A drained result empties the register unless a new one is loaded.
      if (out_valid_r && out_chan.ready && !res_now && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (in_chan.mode)
              MODE_LOAD: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_LOADED;
                out_slot_r   <= in_chan.slot_select;
                out_mac_r    <= '0;
              end
              MODE_ALLOC, MODE_RELEASE: begin
                if (search) begin
                  state_r <= S_SCAN;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_ZERO_IP;
                  out_slot_r   <= '0;
                  out_mac_r    <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (tok_w[POOL_DEPTH].active) begin
            fin_tok_r <= tok_w[POOL_DEPTH];
            fin_idx_r <= idx_w[POOL_DEPTH];
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (fin_tok_r.alloc) begin
              if (fin_tok_r.kind == KIND_HIT) begin
                out_status_r <= ST_EXIST;
                out_slot_r   <= SLOT_W'(fin_idx_r);
                out_mac_r    <= {oui_r, fin_tok_r.tail};
              end else if (fin_free) begin
                out_status_r <= ST_NEW;
                out_slot_r   <= SLOT_W'(fin_idx_r);
                out_mac_r    <= {oui_r, fin_tok_r.tail};
                next_ptr_r   <= nx_ptr;
              end else begin
                out_status_r <= ST_FULL;
                out_slot_r   <= '0;
                out_mac_r    <= '0;
              end
            end else if (fin_tok_r.kind == KIND_HIT) begin
              out_status_r <= ST_RELEASED;
              out_slot_r   <= SLOT_W'(fin_idx_r);
              out_mac_r    <= '0;
            end else begin
              out_status_r <= ST_NOTFOUND;
              out_slot_r   <= '0;
              out_mac_r    <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.mac_address = out_mac_r;

endmodule

// ===== hw/rtl/krr_cell.sv =====
// One slot of the pool: owner, tail and one stage of the search token chain.
module krr_cell import krr_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int SW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] size_i,
  input  logic [IW-1:0] start_i,
  input  krr_wr_t       wr_i,
  input  logic [IW-1:0] wr_idx_i,
  input  krr_ld_t       ld_i,
  input  krr_tok_t      tok_i,
  input  logic [IW-1:0] idx_i,
  output krr_tok_t      tok_o,
  output logic [IW-1:0] idx_o
);

  logic              owner_vld_r;
  logic [IP_W-1:0]   owner_r;
  logic [TAIL_W-1:0] tail_r;
  krr_tok_t          tok_r;
  logic [IW-1:0]     idx_r;

  logic      in_pool;
  logic      hit;
  logic      free;
  krr_kind_t kind;
  krr_tok_t  tok_nxt;
  logic [IW-1:0] idx_nxt;

  // Compare this slot against the passing token.
  always_comb begin
    in_pool = SW'(IDX) < size_i;
    hit     = tok_i.active && in_pool && owner_vld_r && (owner_r == tok_i.ip);
    free    = tok_i.active && tok_i.alloc && in_pool && !owner_vld_r;
    if (hit) begin
      kind = KIND_HIT;
    end else if (free) begin
      kind = (IW'(IDX) >= start_i) ? KIND_FREE : KIND_WRAP;
    end else begin
      kind = KIND_NONE;
    end
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    // A better candidate replaces the carried one; the first of each kind wins.
    if (kind > tok_i.kind) begin
      tok_nxt.kind = kind;
      tok_nxt.tail = tail_r;
      idx_nxt      = IW'(IDX);
    end
  end

  // Slot storage and token stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_vld_r  <= 1'b0;
      tail_r       <= '0;
      tok_r.active <= 1'b0;
    end else begin
      if (wr_i.en && (wr_idx_i == IW'(IDX))) begin
        owner_vld_r <= wr_i.claim;
      end
      if (ld_i.en && (IDX < SEL_SPAN) && (ld_i.sel == SLOT_W'(IDX))) begin
        tail_r <= ld_i.tail;
      end
      tok_r.active <= tok_nxt.active;
    end
    if (wr_i.en && (wr_idx_i == IW'(IDX))) begin
      owner_r <= wr_i.ip;
    end
    tok_r.alloc <= tok_nxt.alloc;
    tok_r.ip    <= tok_nxt.ip;
    tok_r.kind  <= tok_nxt.kind;
    tok_r.tail  <= tok_nxt.tail;
    idx_r       <= idx_nxt;
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ===== hw/rtl/krr_chk.sv =====
// Port-level checker for the slot allocator and its bind to the top level.
`include "keyed_round_robin_slot_allocator_top_defines.svh"

module krr_chk import krr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [MODE_W-1:0]   in_mode,
  input logic [IP_W-1:0]     in_ip_address,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [MAC_W-1:0]    out_mac_address
);

  logic in_acc;
  logic mac_used;
  logic load_req;
  logic zero_req;

  assign in_acc   = in_valid && in_ready;
  assign mac_used = (out_status == ST_EXIST) || (out_status == ST_NEW);
  assign load_req = in_acc && (in_mode == MODE_LOAD);
  assign zero_req = in_acc && ((in_mode == MODE_ALLOC) || (in_mode == MODE_RELEASE)) &&
                    (in_ip_address == '0);

  // A pending result is never overrun by a new item.
  `KRR_ASSERT_NOW(a_no_overrun, in_acc, !out_valid || out_ready)

  // A load is answered in the next cycle.
  `KRR_ASSERT_NEXT(a_load_next, load_req, out_valid && (out_status == ST_LOADED))

  // A zero owner key is rejected in the next cycle.
  `KRR_ASSERT_NEXT(a_zero_ip, zero_req, out_valid && (out_status == ST_ZERO_IP))

  // Only lookups and fresh assignments carry a MAC address.
  `KRR_ASSERT_NOW(a_mac_zero, out_valid && !mac_used, out_mac_address == '0)

  // A stalled result keeps its status.
  `KRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

endmodule

bind keyed_round_robin_slot_allocator_top krr_chk u_krr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_mode         (in_chan.mode),
  .in_ip_address   (in_chan.ip_address),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_mac_address (out_chan.mac_address)
);
